// ----- rtl/core/jfd_pkg.sv -----
// ----------------------------------------------------------------------------
// jfd_pkg: shared types and constants of the JT/T 808 frame deframer
// Byte codes, header layout, status codes and the op format that the
// front part hands to the back part through the op queue.
// ----------------------------------------------------------------------------
package jfd_pkg;

  // link byte codes
  localparam logic [7:0] FlagByte    = 8'h7e;
  localparam logic [7:0] EscByte     = 8'h7d;
  localparam logic [7:0] EscFlagCode = 8'h02;
  localparam logic [7:0] EscEscCode  = 8'h01;

  // frame layout
  localparam int unsigned MaxFrameBytes = 4096;
  localparam int unsigned CountW        = 13;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam int unsigned HdrLen      = 17;
  localparam int unsigned SplitHdrLen = 21;
  localparam int unsigned MinLen      = 18;
  localparam int unsigned SplitBit    = 13;
  localparam int unsigned PhoneBytes  = 10;

  // op queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // result kinds
  localparam logic KindBody    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // summary status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StShort      = 3'd1;
  localparam logic [2:0] StSplitShort = 3'd2;
  localparam logic [2:0] StChecksum   = 3'd3;
  localparam logic [2:0] StLength     = 3'd4;
  localparam logic [2:0] StOverlong   = 3'd5;

  typedef enum logic {
    OP_TAKE,  // one unescaped byte enters the frame
    OP_END    // closing flag: emit summary, clear frame state
  } op_e;

  // one unescaped event; grp_last marks the last op caused by one input byte,
  // next_end says the following op of the same byte is an OP_END
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       grp_last;
    logic       next_end;
  } op_t;

  // what the front pushes in one cycle: zero, one or two ops
  typedef struct packed {
    logic [1:0] n;
    op_t        first;
    op_t        second;
  } push_t;

endpackage

// ----- rtl/core/jfd_front.sv -----
// ----------------------------------------------------------------------------
// jfd_front: flag hunting and escape decoding
// Turns each accepted link byte into zero, one or two unescaped ops.
// ----------------------------------------------------------------------------
module jfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          room_i,
  input  logic [7:0]    byte_in_i,
  output jfd_pkg::push_t push_o
);

  logic in_frame_q, in_frame_d;
  logic esc_q, esc_d;
  logic fire;
  jfd_pkg::push_t push;

  assign fire = in_valid_i && room_i;

  // classify the byte
  always_comb begin
    in_frame_d         = in_frame_q;
    esc_d              = esc_q;
    push.n             = 2'd0;
    push.first.op      = jfd_pkg::OP_TAKE;
    push.first.data    = byte_in_i;
    push.first.grp_last = 1'b1;
    push.first.next_end = 1'b0;
    push.second        = push.first;
    if (!in_frame_q) begin
      if (byte_in_i == jfd_pkg::FlagByte) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
      end
    end else if (byte_in_i == jfd_pkg::FlagByte) begin
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
      if (esc_q) begin
        // dangling escape is a literal 7d ahead of the summary
        push.n              = 2'd2;
        push.first.data     = jfd_pkg::EscByte;
        push.first.grp_last = 1'b0;
        push.first.next_end = 1'b1;
        push.second.op      = jfd_pkg::OP_END;
        push.second.data    = '0;
      end else begin
        push.n          = 2'd1;
        push.first.op   = jfd_pkg::OP_END;
        push.first.data = '0;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (byte_in_i == jfd_pkg::EscFlagCode) begin
        push.n          = 2'd1;
        push.first.data = jfd_pkg::FlagByte;
      end else if (byte_in_i == jfd_pkg::EscEscCode) begin
        push.n          = 2'd1;
        push.first.data = jfd_pkg::EscByte;
      end else if (byte_in_i == jfd_pkg::EscByte) begin
        // literal 7d, and this 7d opens a new escape
        push.n          = 2'd1;
        push.first.data = jfd_pkg::EscByte;
        esc_d           = 1'b1;
      end else begin
        // unknown escape: literal 7d, then the byte itself
        push.n              = 2'd2;
        push.first.data     = jfd_pkg::EscByte;
        push.first.grp_last = 1'b0;
      end
    end else if (byte_in_i == jfd_pkg::EscByte) begin
      esc_d = 1'b1;
    end else begin
      push.n = 2'd1;
    end
    if (!fire) begin
      push.n = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
    end else if (fire) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
    end
  end

endmodule

// ----- rtl/core/jfd_opq.sv -----
// ----------------------------------------------------------------------------
// jfd_opq: op queue between front and back
// Small register FIFO taking up to two ops per cycle and giving one per pop.
// ----------------------------------------------------------------------------
module jfd_opq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jfd_pkg::push_t push_i,
  output logic           room_o,
  output logic           op_valid_o,
  output jfd_pkg::op_t   op_o,
  input  logic           pop_i
);

  jfd_pkg::op_t mem_q [jfd_pkg::QDepth];
  logic [jfd_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [jfd_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic pop;

  // room for a full two-op push
  assign room_o     = cnt_q <= jfd_pkg::QCntW'(jfd_pkg::QDepth - 2);
  assign op_valid_o = cnt_q != '0;
  assign op_o       = mem_q[rd_q];
  assign pop        = pop_i && op_valid_o;

  always_comb begin
    cnt_d = cnt_q + jfd_pkg::QCntW'(push_i.n) - jfd_pkg::QCntW'(pop);
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + 1'b1] <= push_i.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + jfd_pkg::QPtrW'(push_i.n);
      rd_q  <= rd_q + jfd_pkg::QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> cnt_q <= jfd_pkg::QCntW'(jfd_pkg::QDepth - 2))
    else $error("op queue pushed without room");

  a_ptr_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= jfd_pkg::QCntW'(jfd_pkg::QDepth) &&
    (cnt_q == jfd_pkg::QCntW'(jfd_pkg::QDepth) ||
     jfd_pkg::QPtrW'(cnt_q) == jfd_pkg::QPtrW'(wr_q - rd_q)))
    else $error("op queue pointers disagree with count");

endmodule

// ----- rtl/core/jfd_back.sv -----
// ----------------------------------------------------------------------------
// jfd_back: frame state, header capture and result register
// Executes one op per cycle while the result register is not stalled:
// captures header bytes, runs the checksum, streams body bytes one late and builds the frame summary.
// ----------------------------------------------------------------------------
module jfd_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  input  jfd_pkg::op_t op_i,
  output logic         pop_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic         kind_o,
  output logic [7:0]   data_byte_o,
  output logic [15:0]  message_id_o,
  output logic [15:0]  body_attributes_o,
  output logic [7:0]   protocol_version_o,
  output logic [15:0]  phone_high_o,
  output logic [63:0]  phone_low_o,
  output logic [15:0]  serial_number_o,
  output logic [15:0]  total_packets_o,
  output logic [15:0]  packet_number_o,
  output logic [2:0]   status_o,
  output logic         last_o
);

  localparam int unsigned CW = jfd_pkg::CountW;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] id;
    logic [15:0] attr;
    logic [7:0]  version;
    logic [15:0] phone_high;
    logic [63:0] phone_low;
    logic [15:0] serial;
    logic [15:0] total;
    logic [15:0] index;
    logic [2:0]  status;
    logic        last;
  } res_t;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    xor_q, xor_d;
  logic [7:0]    held_q, held_d;
  logic          held_valid_q, held_valid_d;
  logic [15:0]   id_q, id_d;
  logic [15:0]   attr_q, attr_d;
  logic [7:0]    version_q, version_d;
  logic [7:0]    phone_q [jfd_pkg::PhoneBytes];
  logic [7:0]    phone_d [jfd_pkg::PhoneBytes];
  logic [15:0]   serial_q, serial_d;
  logic [15:0]   total_q, total_d;
  logic [15:0]   index_q, index_d;

  logic          out_valid_q, out_valid_d;
  res_t          res_q, res_d;

  logic          fire;
  logic          split;
  logic [CW-1:0] hdr_len, body_end, need_len;
  logic [CW-1:0] p;
  logic [7:0]    b;
  logic          in_body;
  logic [2:0]    status;
  logic [63:0]   phone_low;

  assign pop_o = op_valid_i && (!out_valid_q || out_ready_i);
  assign fire  = pop_o;
  assign p     = cnt_q;
  assign b     = op_i.data;

  // body window and summary status from the current header
  always_comb begin
    split    = attr_q[jfd_pkg::SplitBit];
    hdr_len  = split ? CW'(jfd_pkg::SplitHdrLen) : CW'(jfd_pkg::HdrLen);
    body_end = hdr_len + CW'(attr_q[9:0]);
    need_len = body_end + CW'(1);
    in_body  = (p >= hdr_len) && (p < body_end);
    if ((17'(cnt_q) > 17'(jfd_pkg::MaxFrameBytes)) || (cnt_q == jfd_pkg::CountMax)) begin
      status = jfd_pkg::StOverlong;
    end else if (cnt_q < CW'(jfd_pkg::MinLen)) begin
      status = jfd_pkg::StShort;
    end else if (split && (cnt_q < CW'(jfd_pkg::SplitHdrLen))) begin
      status = jfd_pkg::StSplitShort;
    end else if (xor_q != '0) begin
      status = jfd_pkg::StChecksum;
    end else if (need_len > cnt_q) begin
      status = jfd_pkg::StLength;
    end else begin
      status = jfd_pkg::StOk;
    end
    phone_low = '0;
    for (int i = 2; i < jfd_pkg::PhoneBytes; i++) begin
      phone_low = {phone_low[55:0], phone_q[i]};
    end
  end

  // op execution
  always_comb begin
    cnt_d        = cnt_q;
    xor_d        = xor_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    id_d         = id_q;
    attr_d       = attr_q;
    version_d    = version_q;
    phone_d      = phone_q;
    serial_d     = serial_q;
    total_d      = total_q;
    index_d      = index_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    res_d        = res_q;
    if (fire) begin
      if (op_i.op == jfd_pkg::OP_END) begin
        out_valid_d        = 1'b1;
        res_d.kind         = jfd_pkg::KindSummary;
        res_d.data         = '0;
        res_d.id           = id_q;
        res_d.attr         = attr_q;
        res_d.version      = version_q;
        res_d.phone_high   = {phone_q[0], phone_q[1]};
        res_d.phone_low    = phone_low;
        res_d.serial       = serial_q;
        res_d.total        = split ? total_q : '0;
        res_d.index        = split ? index_q : '0;
        res_d.status       = status;
        res_d.last         = op_i.grp_last;
        // clear the frame for the next opening flag
        cnt_d        = '0;
        xor_d        = '0;
        held_d       = '0;
        held_valid_d = 1'b0;
        id_d         = '0;
        attr_d       = '0;
        version_d    = '0;
        for (int i = 0; i < jfd_pkg::PhoneBytes; i++) begin
          phone_d[i] = '0;
        end
        serial_d = '0;
        total_d  = '0;
        index_d  = '0;
      end else begin
        // header capture by unescaped position
        if (p <= CW'(1)) begin
          if (p == '0) id_d[15:8] = b;
          else         id_d[7:0]  = b;
        end else if (p <= CW'(3)) begin
          if (p == CW'(2)) attr_d[15:8] = b;
          else             attr_d[7:0]  = b;
        end else if (p == CW'(4)) begin
          version_d = b;
        end else if (p <= CW'(14)) begin
          phone_d[4'(p - CW'(5))] = b;
        end else if (p <= CW'(16)) begin
          if (p == CW'(15)) serial_d[15:8] = b;
          else              serial_d[7:0]  = b;
        end else if (p <= CW'(18)) begin
          if (p == CW'(17)) total_d[15:8] = b;
          else              total_d[7:0]  = b;
        end else if (p <= CW'(20)) begin
          if (p == CW'(19)) index_d[15:8] = b;
          else              index_d[7:0]  = b;
        end
        xor_d = xor_q ^ b;
        if (cnt_q != jfd_pkg::CountMax) begin
          cnt_d = cnt_q + CW'(1);
        end
        // the body window never overlaps the attribute bytes
        held_valid_d = in_body;
        if (in_body) begin
          held_d = b;
        end
        // the previously held body byte goes out now
        if (held_valid_q) begin
          out_valid_d      = 1'b1;
          res_d            = '0;
          res_d.kind       = jfd_pkg::KindBody;
          res_d.data       = held_q;
          res_d.status     = jfd_pkg::StOk;
          if (op_i.grp_last) begin
            res_d.last = 1'b1;
          end else if (op_i.next_end) begin
            res_d.last = 1'b0;
          end else begin
            res_d.last = !in_body;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      xor_q        <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      id_q         <= '0;
      attr_q       <= '0;
      version_q    <= '0;
      for (int i = 0; i < jfd_pkg::PhoneBytes; i++) begin
        phone_q[i] <= '0;
      end
      serial_q     <= '0;
      total_q      <= '0;
      index_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      xor_q        <= xor_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      id_q         <= id_d;
      attr_q       <= attr_d;
      version_q    <= version_d;
      phone_q      <= phone_d;
      serial_q     <= serial_d;
      total_q      <= total_d;
      index_q      <= index_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = res_q.kind;
  assign data_byte_o        = res_q.data;
  assign message_id_o       = res_q.id;
  assign body_attributes_o  = res_q.attr;
  assign protocol_version_o = res_q.version;
  assign phone_high_o       = res_q.phone_high;
  assign phone_low_o        = res_q.phone_low;
  assign serial_number_o    = res_q.serial;
  assign total_packets_o    = res_q.total;
  assign packet_number_o    = res_q.index;
  assign status_o           = res_q.status;
  assign last_o             = res_q.last;

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && op_i.op == jfd_pkg::OP_END |=> cnt_q == '0 && !held_valid_q && xor_q == '0)
    else $error("frame state not cleared after summary");

  a_summary_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == jfd_pkg::KindSummary |-> res_q.last)
    else $error("summary not marked last");

  a_body_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == jfd_pkg::KindBody |->
    res_q.status == jfd_pkg::StOk && res_q.id == '0 && res_q.phone_low == '0)
    else $error("body result carries header fields");

endmodule

// ----- rtl/core/jt808_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// jt808_frame_deframer: streaming deframer for JT/T 808 messages
// Usage:
//   Input channel in_valid_i/in_ready_o carries one raw link byte per
//   transfer on byte_in_i. Output channel out_valid_o/out_ready_i carries
//   results: body bytes (kind 0) one byte late, and at the closing 0x7e a
//   frame summary (kind 1) with the captured header and a status code.
//   last_o marks the final result caused by one input byte.
//   Throughput: one byte per cycle while in_ready_o is high; a byte expanding
//   into two unescaped events (unknown escape code, or an escape ahead of the
//   closing flag) takes two back-end ops, absorbed by the four-entry op
//   queue. in_ready_o drops while fewer than two queue slots are free.
//   A stalled receiver holds the result register; the back end then stops
//   and the queue fills until the input side is held off too.
//   Reset clears the frame state; the block starts hunting for a 0x7e.
// ----------------------------------------------------------------------------
module jt808_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] message_id_o,
  output logic [15:0] body_attributes_o,
  output logic [7:0]  protocol_version_o,
  output logic [15:0] phone_high_o,
  output logic [63:0] phone_low_o,
  output logic [15:0] serial_number_o,
  output logic [15:0] total_packets_o,
  output logic [15:0] packet_number_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  jfd_pkg::push_t push;
  jfd_pkg::op_t   op;
  logic           room;
  logic           op_valid;
  logic           pop;

  assign in_ready_o = room;

  // escape decode and flag hunting
  jfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .room_i     (room),
    .byte_in_i  (byte_in_i),
    .push_o     (push)
  );

  // decoupling queue
  jfd_opq u_opq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .op_valid_o (op_valid),
    .op_o       (op),
    .pop_i      (pop)
  );

  // frame state and results
  jfd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_valid_i         (op_valid),
    .op_i               (op),
    .pop_o              (pop),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .kind_o             (kind_o),
    .data_byte_o        (data_byte_o),
    .message_id_o       (message_id_o),
    .body_attributes_o  (body_attributes_o),
    .protocol_version_o (protocol_version_o),
    .phone_high_o       (phone_high_o),
    .phone_low_o        (phone_low_o),
    .serial_number_o    (serial_number_o),
    .total_packets_o    (total_packets_o),
    .packet_number_o    (packet_number_o),
    .status_o           (status_o),
    .last_o             (last_o)
  );

endmodule
